// ===== design/c2s_pkg.sv =====
package c2s_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    // z is scaled so that the squared planar term always fills a 64-bit radicand
    localparam int FRAC_BITS  = 32 - COORD_WIDTH;
    localparam int GUARD_BITS = 24;
    localparam int NUM_ROT    = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int STG_W      = 5;

    localparam int SQR_W      = 2 * COORD_WIDTH;
    localparam int SQ_RAD_W   = 64;
    localparam int SQ_ROOT_W  = 32;
    localparam int SQ_REM_W   = SQ_ROOT_W + 1;
    localparam int RXY_CELLS  = SQ_ROOT_W;

    // CORDIC operands before and after the guard shift
    localparam int OP_W  = 34;
    localparam int CW    = GUARD_BITS + OP_W + 1;
    localparam int ANG_W = 32;

    localparam int ANG_OUT_W = 16;
    localparam int ANG_SHIFT = 15;
    localparam int RND_W     = ANG_W - ANG_SHIFT;

    localparam logic signed [ANG_W-1:0] HALF_PI    = 32'sd536870912;
    localparam logic signed [ANG_W-1:0] ROUND_HALF = 32'sd16384;
    localparam logic [ANG_OUT_W-1:0]    PI_CODE    = 16'h8000;

    // register stages from the input register to the final rounding stage
    localparam int PIPE_DEPTH = 5 + RXY_CELLS + NUM_ROT;
    localparam int AZI_DLY    = PIPE_DEPTH - 2 - NUM_ROT;
    localparam int RAD_DLY    = PIPE_DEPTH - 3 - COORD_WIDTH;

    localparam logic [1:0] OUT_BUF_DEPTH = 2'd2;

    typedef struct packed {
        logic [SQ_RAD_W-1:0]  rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [CW-1:0]    a;
        logic signed [CW-1:0]    b;
        logic signed [ANG_W-1:0] ang;
        logic                    zero;
    } t_cordic;

    // round(atan(2^-k) * 2^30 / pi)
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STG_W-1:0] k);
        logic signed [ANG_W-1:0] v;
        case (k)
            5'd0:    v = 32'sd268435456;
            5'd1:    v = 32'sd158466703;
            5'd2:    v = 32'sd83729454;
            5'd3:    v = 32'sd42502378;
            5'd4:    v = 32'sd21333666;
            5'd5:    v = 32'sd10677233;
            5'd6:    v = 32'sd5339919;
            5'd7:    v = 32'sd2670123;
            5'd8:    v = 32'sd1335082;
            5'd9:    v = 32'sd667543;
            5'd10:   v = 32'sd333772;
            5'd11:   v = 32'sd166886;
            5'd12:   v = 32'sd83443;
            5'd13:   v = 32'sd41722;
            5'd14:   v = 32'sd20861;
            5'd15:   v = 32'sd10430;
            5'd16:   v = 32'sd5215;
            5'd17:   v = 32'sd2608;
            5'd18:   v = 32'sd1304;
            5'd19:   v = 32'sd652;
            5'd20:   v = 32'sd326;
            5'd21:   v = 32'sd163;
            5'd22:   v = 32'sd81;
            5'd23:   v = 32'sd41;
            5'd24:   v = 32'sd20;
            5'd25:   v = 32'sd10;
            5'd26:   v = 32'sd5;
            5'd27:   v = 32'sd3;
            5'd28:   v = 32'sd1;
            5'd29:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/c2s_sqrt_cell.sv =====
module c2s_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  c2s_pkg::t_sqrt i_s,
    output c2s_pkg::t_sqrt o_s
);
    import c2s_pkg::*;

    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] sub;
    logic [SQ_REM_W+1:0] diff;
    logic                fits;
    t_sqrt               n_s;
    t_sqrt               r_s;

    // one root bit: bring down two radicand bits, try subtracting 4*root+1
    always_comb begin
        trial    = {i_s.rem, i_s.rad[SQ_RAD_W-1 -: 2]};
        sub      = {1'b0, i_s.root, 2'b01};
        diff     = trial - sub;
        fits     = (trial >= sub);
        n_s.rad  = i_s.rad << 2;
        n_s.rem  = fits ? diff[SQ_REM_W-1:0] : trial[SQ_REM_W-1:0];
        n_s.root = {i_s.root[SQ_ROOT_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

// ===== design/c2s_cordic_pre.sv =====
module c2s_cordic_pre (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [c2s_pkg::OP_W-1:0] i_a,
    input  logic signed [c2s_pkg::OP_W-1:0] i_b,
    output c2s_pkg::t_cordic               o_s
);
    import c2s_pkg::*;

    logic signed [OP_W-1:0] a_r;
    logic signed [OP_W-1:0] b_r;
    t_cordic                n_s;
    t_cordic                r_s;

    // fold the left half-plane into the right one by a quarter turn
    always_comb begin
        a_r       = i_a;
        b_r       = i_b;
        n_s.ang   = '0;
        n_s.zero  = (i_a == '0) && (i_b == '0);
        if (i_a[OP_W-1]) begin
            if (!i_b[OP_W-1]) begin
                a_r     = i_b;
                b_r     = -i_a;
                n_s.ang = HALF_PI;
            end else begin
                a_r     = -i_b;
                b_r     = i_a;
                n_s.ang = -HALF_PI;
            end
        end
        n_s.a = CW'(a_r) <<< GUARD_BITS;
        n_s.b = CW'(b_r) <<< GUARD_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

// ===== design/c2s_cordic_cell.sv =====
module c2s_cordic_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [c2s_pkg::STG_W-1:0]  i_stage,
    input  c2s_pkg::t_cordic           i_s,
    output c2s_pkg::t_cordic           o_s
);
    import c2s_pkg::*;

    logic signed [CW-1:0]    a;
    logic signed [CW-1:0]    b;
    logic signed [CW-1:0]    da;
    logic signed [CW-1:0]    db;
    logic signed [ANG_W-1:0] step;
    t_cordic                 n_s;
    t_cordic                 r_s;

    // drive b towards zero; b of zero counts as positive
    always_comb begin
        a        = i_s.a;
        b        = i_s.b;
        da       = b >>> i_stage;
        db       = a >>> i_stage;
        step     = atan_entry(i_stage);
        n_s.zero = i_s.zero;
        if (!b[CW-1]) begin
            n_s.a   = a + da;
            n_s.b   = b - db;
            n_s.ang = i_s.ang + step;
        end else begin
            n_s.a   = a - da;
            n_s.b   = b + db;
            n_s.ang = i_s.ang - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

// ===== design/cartesian_to_spherical.sv =====
// Throughput: one point per cycle while o_stall is low; every cell is a single register
// stage and all rows advance together.
// A two-entry output buffer lets the pipe keep filling while a result waits.
// Reset (synchronous, active low) clears stage valid bits and the output buffer.
module cartesian_to_spherical (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_y_coord,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_z_coord,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [c2s_pkg::COORD_WIDTH-1:0]        o_radius,
    output logic [c2s_pkg::ANG_OUT_W-1:0]          o_polar_angle,
    output logic signed [c2s_pkg::ANG_OUT_W-1:0]   o_azimuth
);
    import c2s_pkg::*;

    localparam int W = COORD_WIDTH;

    logic                         en;
    logic                         push;
    logic                         pop;
    logic [PIPE_DEPTH-1:0]        r_vld;

    logic signed [W-1:0]          r_x;
    logic signed [W-1:0]          r_y;
    logic signed [W-1:0]          r_z;
    logic signed [SQR_W-1:0]      xx_p;
    logic signed [SQR_W-1:0]      yy_p;
    logic signed [SQR_W-1:0]      zz_p;
    logic [SQR_W-1:0]             r_xx;
    logic [SQR_W-1:0]             r_yy;
    logic [SQR_W-1:0]             r_zz;
    logic [SQR_W-1:0]             r_sxy;
    logic [SQR_W-1:0]             r_sum;
    logic signed [W-1:0]          r_zd [RXY_CELLS+2];

    t_sqrt                        rxy_s [RXY_CELLS+1];
    t_sqrt                        rad_s [W+1];
    t_cordic                      pol_s [NUM_ROT+1];
    t_cordic                      azi_s [NUM_ROT+1];

    logic signed [ANG_W-1:0]      pol_sum;
    logic signed [ANG_W-1:0]      azi_sum;
    logic [RND_W-1:0]             pol_rnd;
    logic [ANG_OUT_W-1:0]         n_pol;
    logic signed [ANG_OUT_W-1:0]  n_azi;
    logic [W-1:0]                 n_rad;
    logic [ANG_OUT_W-1:0]         r_pol;
    logic signed [ANG_OUT_W-1:0]  r_azd [AZI_DLY];
    logic [W-1:0]                 r_rdd [RAD_DLY];

    logic [W-1:0]                 r_ob_rad [2];
    logic [ANG_OUT_W-1:0]         r_ob_pol [2];
    logic signed [ANG_OUT_W-1:0]  r_ob_azi [2];
    logic                         r_wr;
    logic                         r_rd;
    logic [1:0]                   r_cnt;

    // the pipe only halts when a finished item cannot enter a full buffer
    assign en      = !(r_vld[PIPE_DEPTH-1] && (r_cnt == OUT_BUF_DEPTH));
    assign o_stall = !en;
    assign push    = en && r_vld[PIPE_DEPTH-1];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // input, squares and sums
    assign xx_p = r_x * r_x;
    assign yy_p = r_y * r_y;
    assign zz_p = r_z * r_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x      <= i_x_coord;
            r_y      <= i_y_coord;
            r_z      <= i_z_coord;
            r_xx     <= $unsigned(xx_p);
            r_yy     <= $unsigned(yy_p);
            r_zz     <= $unsigned(zz_p);
            r_sxy    <= r_xx + r_yy;
            r_sum    <= r_xx + r_yy + r_zz;
            r_zd[0]  <= r_z;
            for (int k = 1; k < RXY_CELLS + 2; k++) begin
                r_zd[k] <= r_zd[k-1];
            end
        end
    end

    // square-root rows: planar length scaled by 2^FRAC_BITS, and the radius
    always_comb begin
        rxy_s[0].rad  = SQ_RAD_W'(r_sxy) << (2 * FRAC_BITS);
        rxy_s[0].rem  = '0;
        rxy_s[0].root = '0;
        rad_s[0].rad  = SQ_RAD_W'(r_sum) << (2 * FRAC_BITS);
        rad_s[0].rem  = '0;
        rad_s[0].root = '0;
    end

    for (genvar k = 0; k < RXY_CELLS; k++) begin : g_rxy
        c2s_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_s   (rxy_s[k]),
            .o_s   (rxy_s[k+1])
        );
    end

    for (genvar k = 0; k < W; k++) begin : g_rad
        c2s_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_s   (rad_s[k]),
            .o_s   (rad_s[k+1])
        );
    end

    // CORDIC rows: polar angle atan2(rxy, z) and azimuth atan2(y, x)
    c2s_cordic_pre u_pol_pre (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (OP_W'(r_zd[RXY_CELLS+1]) <<< FRAC_BITS),
        .i_b   (OP_W'(rxy_s[RXY_CELLS].root)),
        .o_s   (pol_s[0])
    );

    c2s_cordic_pre u_azi_pre (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (OP_W'(r_x)),
        .i_b   (OP_W'(r_y)),
        .o_s   (azi_s[0])
    );

    for (genvar k = 0; k < NUM_ROT; k++) begin : g_rot
        c2s_cordic_cell u_pol (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_stage (STG_W'(k)),
            .i_s     (pol_s[k]),
            .o_s     (pol_s[k+1])
        );
        c2s_cordic_cell u_azi (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_stage (STG_W'(k)),
            .i_s     (azi_s[k]),
            .o_s     (azi_s[k+1])
        );
    end

    // rounding to 16-bit binary angles, polar clamped to [0, pi], radius rounded; the origin gives zero angles
    always_comb begin
        pol_sum = pol_s[NUM_ROT].ang + ROUND_HALF;
        azi_sum = azi_s[NUM_ROT].ang + ROUND_HALF;
        pol_rnd = pol_sum[ANG_W-1:ANG_SHIFT];
        if (pol_s[NUM_ROT].zero || pol_rnd[RND_W-1]) begin
            n_pol = '0;
        end else if (pol_rnd[ANG_OUT_W-1:0] > PI_CODE) begin
            n_pol = PI_CODE;
        end else begin
            n_pol = pol_rnd[ANG_OUT_W-1:0];
        end
        if (azi_s[NUM_ROT].zero) begin
            n_azi = '0;
        end else begin
            n_azi = azi_sum[ANG_SHIFT+ANG_OUT_W-1:ANG_SHIFT];
        end
        n_rad = rad_s[W].root[W-1:0]
              + W'(rad_s[W].rem > SQ_REM_W'(rad_s[W].root));
    end

    // align radius and azimuth with the longer polar path
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pol    <= n_pol;
            r_azd[0] <= n_azi;
            for (int k = 1; k < AZI_DLY; k++) begin
                r_azd[k] <= r_azd[k-1];
            end
            r_rdd[0] <= n_rad;
            for (int k = 1; k < RAD_DLY; k++) begin
                r_rdd[k] <= r_rdd[k-1];
            end
        end
    end

    // output buffer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ob_rad[r_wr] <= r_rdd[RAD_DLY-1];
            r_ob_pol[r_wr] <= r_pol;
            r_ob_azi[r_wr] <= r_azd[AZI_DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assign o_valid       = (r_cnt != '0);
    assign o_radius      = r_ob_rad[r_rd];
    assign o_polar_angle = r_ob_pol[r_rd];
    assign o_azimuth     = r_ob_azi[r_rd];

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OUT_BUF_DEPTH)
        else $error("output buffer overfilled");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_cnt == 2'($past(r_cnt) + {1'b0, $past(push)} - {1'b0, $past(pop)}))
        else $error("buffer count lost a transfer");

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_vld[PIPE_DEPTH-1])
        else $error("finished item dropped while halted");

    a_polar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_polar_angle <= PI_CODE)
        else $error("polar angle beyond pi");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import c2s_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        logic [COORD_WIDTH-1:0]      radius;
        logic [ANG_OUT_W-1:0]        polar_angle;
        logic signed [ANG_OUT_W-1:0] azimuth;
    } t_sph;

    localparam int RANDOM_POINTS  = 1430;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    localparam longint QUARTER_TURN = 64'sd536870912;
    localparam longint ROUND_BIAS   = 64'sd16384;
    localparam longint PI_BAM       = 64'sd32768;

    // atan(2^-k) in units of pi / 2^30
    localparam longint ATAN_LUT [32] = '{
        268435456, 158466703, 83729454, 42502378, 21333666, 10677233, 5339919,
        2670123, 1335082, 667543, 333772, 166886, 83443, 41722, 20861, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0
    };

    localparam int DIRECTED [20][3] = '{
        '{0, 0, 0},
        '{32767, 32767, 32767},
        '{-32768, -32768, -32768},
        '{-32768, 0, 0},
        '{-1, 0, 0},
        '{0, 0, 32767},
        '{0, 0, -32768},
        '{0, 0, 1},
        '{0, 0, -1},
        '{32767, 0, 0},
        '{0, 32767, 0},
        '{0, -32768, 0},
        '{-32768, -1, 0},
        '{-32768, 1, 0},
        '{1, 1, 1},
        '{-1, -1, -1},
        '{32767, -32768, 0},
        '{0, 32767, -32768},
        '{-32768, 32767, -32768},
        '{12345, -23456, 345}
    };

    class c2s_scoreboard;
        t_sph pending[$];
        int   errors;
        int   checked;
        int   noted;
        int   pi_wraps;
        int   polar_at_pi;
        int   origins;

        function new();
            errors      = 0;
            checked     = 0;
            noted       = 0;
            pi_wraps    = 0;
            polar_at_pi = 0;
            origins     = 0;
        endfunction

        function void log_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("[%0t] ERROR: %s", $realtime, msg);
            end
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned probe;
            res   = 0;
            probe = 64'h4000_0000_0000_0000;
            while (probe > v) probe >>= 2;
            while (probe != 0) begin
                if (v >= res + probe) begin
                    v  -= res + probe;
                    res = (res >> 1) + probe;
                end else begin
                    res >>= 1;
                end
                probe >>= 2;
            end
            return res;
        endfunction

        // atan2(b, a) by vectoring, units of pi / 2^30
        static function longint vector_angle(longint a, longint b);
            longint ang;
            longint t;
            longint da;
            longint db;
            if (a == 0 && b == 0) return 0;
            ang = 0;
            if (a < 0) begin
                if (b >= 0) begin
                    t   = b;
                    b   = -a;
                    a   = t;
                    ang = QUARTER_TURN;
                end else begin
                    t   = -b;
                    b   = a;
                    a   = t;
                    ang = -QUARTER_TURN;
                end
            end
            a = a <<< GUARD_BITS;
            b = b <<< GUARD_BITS;
            for (int k = 0; k < NUM_ROT; k++) begin
                da = b >>> k;
                db = a >>> k;
                if (b >= 0) begin
                    a   += da;
                    b   -= db;
                    ang += ATAN_LUT[k];
                end else begin
                    a   -= da;
                    b   += db;
                    ang -= ATAN_LUT[k];
                end
            end
            return ang;
        endfunction

        static function longint to_bam(longint ang);
            return (ang + ROUND_BIAS) >>> ANG_SHIFT;
        endfunction

        function void note_point(t_coord x, t_coord y, t_coord z);
            longint          sx, sy, sz;
            longint          rxy, zf, pol, azi;
            longint unsigned ax, ay, az, sxy, sum, r;
            t_sph            e;
            sx  = x;
            sy  = y;
            sz  = z;
            ax  = (sx < 0) ? -sx : sx;
            ay  = (sy < 0) ? -sy : sy;
            az  = (sz < 0) ? -sz : sz;
            sxy = ax * ax + ay * ay;
            sum = sxy + az * az;
            r   = int_sqrt(sum);
            if (sum - r * r > r) r++;

            rxy = longint'(int_sqrt(sxy << (2 * FRAC_BITS)));
            zf  = sz <<< FRAC_BITS;
            pol = to_bam(vector_angle(zf, rxy));
            if (pol < 0) pol = 0;
            if (pol > PI_BAM) pol = PI_BAM;
            azi = to_bam(vector_angle(sx, sy));

            e.radius      = r[COORD_WIDTH-1:0];
            e.polar_angle = pol[ANG_OUT_W-1:0];
            e.azimuth     = azi[ANG_OUT_W-1:0];
            pending.push_back(e);

            noted++;
            if (e.azimuth == PI_CODE) pi_wraps++;
            if (e.polar_angle == PI_CODE) polar_at_pi++;
            if (sum == 0) origins++;
        endfunction

        function void check_result(t_sph got);
            t_sph e;
            checked++;
            if (pending.size() == 0) begin
                log_error($sformatf("result with nothing outstanding: r=%0d pol=%0d azi=%0d",
                                    got.radius, got.polar_angle, got.azimuth));
                return;
            end
            e = pending.pop_front();
            if (got.radius !== e.radius || got.polar_angle !== e.polar_angle ||
                got.azimuth !== e.azimuth) begin
                log_error($sformatf({"result %0d: radius exp %0d got %0d, ",
                                     "polar exp %0d got %0d, azimuth exp %0d got %0d"},
                                    checked, e.radius, got.radius, e.polar_angle,
                                    got.polar_angle, e.azimuth, got.azimuth));
            end
        endfunction

        function void flush();
            t_sph e;
            while (pending.size() != 0) begin
                e = pending.pop_front();
                log_error($sformatf("missing result: radius %0d polar %0d azimuth %0d",
                                    e.radius, e.polar_angle, e.azimuth));
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_coord i_x_coord;
    t_coord i_y_coord;
    t_coord i_z_coord;
    logic   o_valid;
    logic   i_stall;
    logic [COORD_WIDTH-1:0]      o_radius;
    logic [ANG_OUT_W-1:0]        o_polar_angle;
    logic signed [ANG_OUT_W-1:0] o_azimuth;

    c2s_scoreboard sb;
    int            burst_left;

    cartesian_to_spherical i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_z_coord     (i_z_coord),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_radius      (o_radius),
        .o_polar_angle (o_polar_angle),
        .o_azimuth     (o_azimuth)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_coord rand_full();
        return t_coord'($urandom);
    endfunction

    function automatic t_coord rand_small();
        return t_coord'(int'($urandom_range(0, 16)) - 8);
    endfunction

    function automatic t_coord pick_extreme();
        case ($urandom_range(0, 5))
            0:       return t_coord'(-32768);
            1:       return t_coord'(-32767);
            2:       return t_coord'(-1);
            3:       return t_coord'(0);
            4:       return t_coord'(1);
            default: return t_coord'(32767);
        endcase
    endfunction

    // burst/gap pacing of the sender; roughly a quarter of bursts follow on with no gap
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_point(input t_coord x, input t_coord y, input t_coord z);
        i_valid   <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        i_z_coord <= z;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        sb.note_point(x, y, z);
        @(posedge i_clk);
    endtask

    // receiver back-pressure: random modes of no stall, 30% stall, 85% stall or alternating stall
    initial begin : receiver
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 99) < 30);
                2:       i_stall <= ($urandom_range(0, 99) < 85);
                default: i_stall <= mode_left[0];
            endcase
        end
    end

    // handshakes are settled by the falling edge, so sample there
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result('{o_radius, o_polar_angle, o_azimuth});
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        t_coord x, y, z;
        int     mask;
        sb         = new();
        burst_left = 0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_x_coord <= '0;
        i_y_coord <= '0;
        i_z_coord <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            pace();
            send_point(t_coord'(DIRECTED[i][0]), t_coord'(DIRECTED[i][1]),
                       t_coord'(DIRECTED[i][2]));
        end

        for (int n = 0; n < RANDOM_POINTS; n++) begin
            x = rand_full();
            y = rand_full();
            z = rand_full();
            case ($urandom_range(0, 9))
                4: begin
                    x = rand_small();
                    y = rand_small();
                    z = rand_small();
                end
                5: begin
                    // one or two axes zeroed
                    mask = $urandom_range(1, 6);
                    if (mask & 1) x = '0;
                    if (mask & 2) y = '0;
                    if (mask & 4) z = '0;
                end
                6: begin
                    x = pick_extreme();
                    y = pick_extreme();
                    z = pick_extreme();
                end
                7: begin
                    // close to the z axis
                    x = rand_small();
                    y = rand_small();
                end
                8: begin
                    // negative x axis, azimuth around the wrap
                    x = t_coord'(-int'($urandom_range(1, 32768)));
                    y = rand_small();
                end
                9: begin
                    x = pick_extreme();
                    z = rand_small();
                end
                default: ;
            endcase
            pace();
            send_point(x, y, z);
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flush();

        $display("Converted %0d points (%0d directed, %0d random) under sender gaps and stalls",
                 sb.noted, $size(DIRECTED, 1), RANDOM_POINTS);
        $display("Checked %0d results: %0d azimuth wraps, %0d polar at pi, %0d origins",
                 sb.checked, sb.pi_wraps, sb.polar_at_pi, sb.origins);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches in total", sb.errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
